/* design/hsl2rgb_pkg.sv */
// shared constants and types for the hsl to rgb converter
package hsl2rgb_pkg;

    localparam int N_STAGES = 6;

    // hue position k in units of 1/1024, one turn is 12 units of 1024
    localparam int KF_W = 14;
    localparam logic [KF_W:0] KF_TURN = 15'd12288;
    localparam logic [KF_W-1:0] OFS_RED = 14'd0;
    localparam logic [KF_W-1:0] OFS_GREEN = 14'd8192;
    localparam logic [KF_W-1:0] OFS_BLUE = 14'd4096;

    localparam logic signed [KF_W:0] K_UP = 15'sd3072;
    localparam logic signed [KF_W:0] K_DOWN = 15'sd9216;
    localparam logic signed [KF_W:0] T_MAX = 15'sd1024;
    localparam logic signed [KF_W:0] T_MIN = -15'sd1024;
    localparam int T_W = 12;

    localparam int SM_W = 15;
    localparam int NUM_W = 27;
    localparam logic [NUM_W-1:0] LIG_SCALE = 27'd261120;

    // rounding offset, half of 255 * 261120
    localparam logic [NUM_W-1:0] FULL_HALF = 27'd33292800;

    // reciprocal of 65025 for the final divide, after a 10 bit shift
    localparam int DROP_BITS = 10;
    localparam int RECIP_SHIFT = 45;
    localparam int RECIP_W = 30;
    localparam longint DIV_REST = 65025;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_REST - 1)) / 64'(DIV_REST));

    typedef struct packed {
        logic [N_STAGES-1:0] en;
    } t_pipe_ctl;

endpackage

/* design/hsl_to_rgb_converter.sv */
// throughput: one word per cycle, a stall holds each stage without loss
// the rate is set by the six-stage pipeline, one register stage per step
// ready runs back through the stages, so a bubble is filled at once
// reset clears the stage valid bits only; the datapath is not reset
module hsl_to_rgb_converter
    import hsl2rgb_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [11:0]             i_hue,
    input  logic [7:0]              i_saturation,
    input  logic [7:0]              i_lightness,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [CHANNEL_BITS-1:0] o_red,
    output logic [CHANNEL_BITS-1:0] o_green,
    output logic [CHANNEL_BITS-1:0] o_blue
);

    localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;

    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] n_vld;
    logic [N_STAGES-1:0] rdy;
    t_pipe_ctl           ctl;

    logic [7:0]          lig_inv;
    logic [6:0]          n_m;
    logic [7:0]          r_sat1;
    logic [7:0]          r_lig1;
    logic [6:0]          r_m1;
    logic [SM_W-1:0]     r_sm2;
    logic [7:0]          r_lig2;
    logic [NUM_W-1:0]    r_base3;

    // stage moves when it is empty or the next one moves
    always_comb begin
        rdy[N_STAGES-1] = i_ready || !r_vld[N_STAGES-1];
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            rdy[k] = rdy[k+1] || !r_vld[k];
        end
    end

    assign ctl.en = rdy;

    always_comb begin
        n_vld = r_vld;
        if (rdy[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < N_STAGES; k++) begin
            if (rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // m = min(L, 255 - L)
    assign lig_inv = 8'd255 - i_lightness;
    assign n_m = i_lightness[7] ? lig_inv[6:0] : i_lightness[6:0];

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_sat1 <= i_saturation;
            r_lig1 <= i_lightness;
            r_m1 <= n_m;
        end
        if (rdy[1]) begin
            r_sm2 <= SM_W'(r_sat1) * SM_W'(r_m1);
            r_lig2 <= r_lig1;
        end
        if (rdy[2]) begin
            r_base3 <= NUM_W'(r_lig2) * LIG_SCALE;
        end
    end

    hsl2rgb_chan #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .HUE_OFFSET   (OFS_RED)
    ) u_red (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_hue   (i_hue),
        .i_sm    (r_sm2),
        .i_base  (r_base3),
        .o_level (o_red)
    );

    hsl2rgb_chan #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .HUE_OFFSET   (OFS_GREEN)
    ) u_green (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_hue   (i_hue),
        .i_sm    (r_sm2),
        .i_base  (r_base3),
        .o_level (o_green)
    );

    hsl2rgb_chan #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .HUE_OFFSET   (OFS_BLUE)
    ) u_blue (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_hue   (i_hue),
        .i_sm    (r_sm2),
        .i_base  (r_base3),
        .o_level (o_blue)
    );

    assign o_ready = rdy[0];
    assign o_valid = r_vld[N_STAGES-1];

    a_full_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input side stalled while output side is ready");

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> o_ready)
        else $error("empty first stage refuses a word");

    a_word_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && rdy[1]) |=> r_vld[1])
        else $error("word lost between first and second stage");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red <= CH_MAX && o_green <= CH_MAX && o_blue <= CH_MAX))
        else $error("channel level above full scale");

endmodule

/* design/hsl2rgb_chan.sv */
// one color channel of the hsl to rgb pipeline
module hsl2rgb_chan
    import hsl2rgb_pkg::*;
#(
    parameter int CHANNEL_BITS = 8,
    parameter logic [KF_W-1:0] HUE_OFFSET = 14'd0
)
(
    input  logic                    i_clk,
    input  t_pipe_ctl               i_ctl,
    input  logic [11:0]             i_hue,
    input  logic [SM_W-1:0]         i_sm,
    input  logic [NUM_W-1:0]        i_base,
    output logic [CHANNEL_BITS-1:0] o_level
);

    localparam int YW = CHANNEL_BITS + 16;
    localparam int XW = CHANNEL_BITS + NUM_W + 1;
    localparam int PW = YW + RECIP_W;
    localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;

    logic [KF_W:0]                kf_sum;
    logic [KF_W-1:0]              n_kf;
    logic [KF_W-1:0]              r_kf;
    logic signed [KF_W:0]         up;
    logic signed [KF_W:0]         down;
    logic signed [KF_W:0]         t_raw;
    logic signed [KF_W:0]         t_clip;
    logic signed [T_W-1:0]        r_t;
    logic signed [SM_W:0]         sm_s;
    logic signed [NUM_W:0]        prod_full;
    logic signed [NUM_W-1:0]      r_prod;
    logic signed [NUM_W:0]        diff;
    logic [NUM_W-1:0]             n_num;
    logic [NUM_W-1:0]             r_num;
    logic [XW-1:0]                x_sum;
    logic [YW-1:0]                r_y;
    logic [PW-1:0]                q_full;
    logic [CHANNEL_BITS:0]        q;
    logic [CHANNEL_BITS-1:0]      n_level;
    logic [CHANNEL_BITS-1:0]      r_level;

    // k = (offset + 3 * hue) mod one turn
    always_comb begin
        kf_sum = 15'(i_hue) * 15'd3 + 15'(HUE_OFFSET);
        if (kf_sum >= KF_TURN) begin
            n_kf = KF_W'(kf_sum - KF_TURN);
        end else begin
            n_kf = kf_sum[KF_W-1:0];
        end
    end

    // clamp(min(k - 3, 9 - k), -1, 1)
    always_comb begin
        up = signed'({1'b0, r_kf}) - K_UP;
        down = K_DOWN - signed'({1'b0, r_kf});
        t_raw = (up < down) ? up : down;
        if (t_raw > T_MAX) begin
            t_clip = T_MAX;
        end else if (t_raw < T_MIN) begin
            t_clip = T_MIN;
        end else begin
            t_clip = t_raw;
        end
    end

    assign sm_s = signed'({1'b0, i_sm});
    assign prod_full = (NUM_W + 1)'(sm_s) * (NUM_W + 1)'(r_t);

    always_comb begin
        diff = signed'({1'b0, i_base}) - signed'({r_prod[NUM_W-1], r_prod});
        n_num = diff[NUM_W] ? '0 : diff[NUM_W-1:0];
    end

    assign x_sum = XW'(r_num) * XW'(CH_MAX) + XW'(FULL_HALF);
    assign q_full = PW'(r_y) * PW'(RECIP);
    assign q = q_full[RECIP_SHIFT +: CHANNEL_BITS + 1];
    assign n_level = (q > (CHANNEL_BITS + 1)'(CH_MAX)) ? CH_MAX : q[CHANNEL_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_kf <= n_kf;
        end
        if (i_ctl.en[1]) begin
            r_t <= t_clip[T_W-1:0];
        end
        if (i_ctl.en[2]) begin
            r_prod <= prod_full[NUM_W-1:0];
        end
        if (i_ctl.en[3]) begin
            r_num <= n_num;
        end
        if (i_ctl.en[4]) begin
            r_y <= x_sum[DROP_BITS +: YW];
        end
        if (i_ctl.en[5]) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

/* bench/hsl_to_rgb_converter_test.sv */
// self-checking testbench for the hsl to rgb converter, random and directed pixels
`timescale 1ns / 1ps

module hsl_to_rgb_converter_test;

    localparam int CHANNEL_BITS = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 650;
    localparam int LONG_HOLD = 300;
    localparam int TAIL_CYCLES = 20;

    localparam longint HUE_UNIT = 1024;
    localparam longint HUE_TURN = 12288;
    localparam longint LIG_SCALE = 261120;
    localparam longint FULL_DEN = 66585600;
    localparam longint RED_OFS = 0;
    localparam longint GREEN_OFS = 8;
    localparam longint BLUE_OFS = 4;

    localparam int unsigned DIR_HUE[20] = '{0, 4095, 0, 4095, 0, 682, 683, 1365, 1366, 2048,
                                            2730, 2731, 3413, 3414, 1024, 3072, 341, 342,
                                            2048, 4095};
    localparam int unsigned DIR_SAT[20] = '{255, 255, 0, 255, 255, 255, 200, 255, 255, 128,
                                            255, 255, 17, 255, 255, 0, 255, 90, 255, 0};
    localparam int unsigned DIR_LIG[20] = '{128, 128, 0, 255, 0, 127, 128, 128, 128, 64,
                                            200, 128, 128, 128, 255, 255, 128, 30, 128, 128};

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_rgb;

    class t_rgb_tracker;
        t_rgb pending_rgb[$];
        int unsigned errors;

        function logic [CHANNEL_BITS-1:0] channel_level(longint ofs, longint hue,
                                                        longint sat, longint lig);
            longint kf, up, down, t, m, num, top, lvl;
            top = (longint'(1) << CHANNEL_BITS) - 1;
            kf = (ofs * HUE_UNIT + 3 * hue) % HUE_TURN;
            up = kf - 3 * HUE_UNIT;
            down = 9 * HUE_UNIT - kf;
            t = (up < down) ? up : down;
            if (t > HUE_UNIT) t = HUE_UNIT;
            if (t < -HUE_UNIT) t = -HUE_UNIT;
            m = (lig < 255 - lig) ? lig : 255 - lig;
            num = lig * LIG_SCALE - sat * m * t;
            if (num < 0) num = 0;
            lvl = (top * num + FULL_DEN / 2) / FULL_DEN;
            if (lvl > top) lvl = top;
            return lvl[CHANNEL_BITS-1:0];
        endfunction

        function void note_input(logic [11:0] hue, logic [7:0] sat, logic [7:0] lig);
            t_rgb want;
            want.red = channel_level(RED_OFS, hue, sat, lig);
            want.green = channel_level(GREEN_OFS, hue, sat, lig);
            want.blue = channel_level(BLUE_OFS, hue, sat, lig);
            pending_rgb.push_back(want);
        endfunction

        task report(string what, longint want, longint got);
            $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
            errors++;
        endtask

        task check_result(logic [CHANNEL_BITS-1:0] r, logic [CHANNEL_BITS-1:0] g,
                          logic [CHANNEL_BITS-1:0] b);
            t_rgb want;
            if (pending_rgb.size() == 0) begin
                report("unexpected word", 0, 1);
            end else begin
                want = pending_rgb.pop_front();
                if (r !== want.red) report("red", want.red, r);
                if (g !== want.green) report("green", want.green, g);
                if (b !== want.blue) report("blue", want.blue, b);
            end
        endtask

        function int outstanding();
            return pending_rgb.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic [11:0]             i_hue = '0;
    logic [7:0]              i_saturation = '0;
    logic [7:0]              i_lightness = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [CHANNEL_BITS-1:0] o_red;
    logic [CHANNEL_BITS-1:0] o_green;
    logic [CHANNEL_BITS-1:0] o_blue;

    t_rgb_tracker board = new;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_cycles = 0;
    int unsigned quiet_cycles = 0;

    hsl_to_rgb_converter #(.CHANNEL_BITS(CHANNEL_BITS)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_hue(i_hue),
        .i_saturation(i_saturation),
        .i_lightness(i_lightness),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_red(o_red),
        .o_green(o_green),
        .o_blue(o_blue)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) board.note_input(i_hue, i_saturation, i_lightness);
        if (i_rst_n && o_valid && i_ready) board.check_result(o_red, o_green, o_blue);
    end

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task send_pixel(logic [11:0] hue, logic [7:0] sat, logic [7:0] lig);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_hue <= hue;
        i_saturation <= sat;
        i_lightness <= lig;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task drain_pixels();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    function logic [7:0] level_pick();
        if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(255));
    endfunction

    task send_random(int unsigned count, bit with_hold);
        for (int unsigned n = 0; n < count; n++) begin
            if (with_hold && n == count / 2) hold_cycles = LONG_HOLD;
            send_pixel(12'($urandom_range(4095)), level_pick(), level_pick());
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 20; i++) begin
            send_pixel(12'(DIR_HUE[i]), 8'(DIR_SAT[i]), 8'(DIR_LIG[i]));
        end
        drain_pixels();

        send_idle_pct = 12;
        recv_idle_pct = 51;
        send_random(ITEMS_PER_PHASE, 1'b0);
        drain_pixels();

        send_idle_pct = 51;
        recv_idle_pct = 12;
        send_random(ITEMS_PER_PHASE, 1'b0);
        drain_pixels();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(ITEMS_PER_PHASE, 1'b1);
        drain_pixels();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
